/* design/origin_shift_maze_walker_unit_assert.svh */
// assertion macros for the origin shift maze walker
`ifndef ORIGIN_SHIFT_MAZE_WALKER_UNIT_ASSERT_SVH
`define ORIGIN_SHIFT_MAZE_WALKER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define OSMW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define OSMW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OSMW_ASSERT(lbl, prop, msg)
`define OSMW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/osmw_pkg.sv */
package osmw_pkg;

  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int CELLS      = MAX_ROWS * MAX_COLS;
  localparam int DIM_W      = 7;
  localparam int IDX_W      = 12;
  localparam int CNT_W      = 12;
  localparam int AREA_W     = 2 * DIM_W;
  localparam int DIV_STEP_W = $clog2(IDX_W);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(16);

  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_SHIFT = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] STEP_UP    = 2'd0;
  localparam logic [1:0] STEP_RIGHT = 2'd1;
  localparam logic [1:0] STEP_DOWN  = 2'd2;
  localparam logic [1:0] STEP_LEFT  = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SHIFT_WB,
    ST_RD_DIV,
    ST_RD_MEM
  } state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       step_dir;
    logic [IDX_W-1:0] cell_index;
  } req_t;

  typedef struct packed {
    logic [5:0]       origin_row;
    logic [5:0]       origin_col;
    logic             moved;
    logic [CNT_W-1:0] remaining;
    logic             complete;
    logic [1:0]       cell_dir;
  } rsp_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] quot;
    logic [DIM_W-1:0] rem;
  } div_res_t;

endpackage

/* design/osmw_ram.sv */
module osmw_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [DATA_BITS-1:0] wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/osmw_div.sv */
module osmw_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [osmw_pkg::IDX_W-1:0] dividend,
  input  logic [osmw_pkg::DIM_W-1:0] divisor,
  output osmw_pkg::div_res_t         res
);

  logic                            run;
  logic                            done;
  logic [osmw_pkg::DIV_STEP_W-1:0] steps;
  logic [osmw_pkg::IDX_W-1:0]      quot;
  logic [osmw_pkg::DIM_W-1:0]      rem;
  logic [osmw_pkg::DIM_W-1:0]      dvs;
  logic [osmw_pkg::DIM_W:0]        partial;
  logic [osmw_pkg::DIM_W+1:0]      diff;
  logic                            borrow;

  // one quotient bit per cycle, restoring
  always_comb begin
    partial = {rem, quot[osmw_pkg::IDX_W-1]};
    diff    = {1'b0, partial} - {2'b00, dvs};
    borrow  = diff[osmw_pkg::DIM_W+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
      end else if (run && steps == osmw_pkg::DIV_STEP_W'(osmw_pkg::IDX_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quot  <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      steps <= '0;
    end else if (run) begin
      quot  <= {quot[osmw_pkg::IDX_W-2:0], ~borrow};
      rem   <= borrow ? partial[osmw_pkg::DIM_W-1:0] : diff[osmw_pkg::DIM_W-1:0];
      steps <= steps + osmw_pkg::DIV_STEP_W'(1);
    end
  end

  assign res = {done, quot, rem};

endmodule

/* design/origin_shift_maze_walker_unit.sv */
// channel   | signals                          | handshake
// ----------+----------------------------------+-------------------------------
// request   | start, busy, req                 | taken when start and !busy
// result    | done, rsp                        | one-cycle strobe, no back-pressure
// config    | cfg_valid, cfg_ready, cfg_index, | written when cfg_valid and
//           | cfg_data                         | cfg_ready (ready always high)
//
// start command: a sweep of the pointer and visited memories
// shift command: one read-modify-write of the visited memory
// read command: 12-step divider for the cell index, then a memory read
// rejected shift, out-of-range read, unused command: answered from idle without a memory access
// synchronous reset gives 16 x 16 and origin (0, 0), no clearing pass
// the result is registered; a new request is taken while it is shown
`include "origin_shift_maze_walker_unit_assert.svh"

module origin_shift_maze_walker_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  osmw_pkg::req_t             req,
  output logic                       done,
  output osmw_pkg::rsp_t             rsp,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [osmw_pkg::DIM_W-1:0] cfg_data
);

  osmw_pkg::state_t            state, state_next;
  logic [osmw_pkg::DIM_W-1:0]  grid_rows, grid_cols;
  logic [osmw_pkg::DIM_W-1:0]  rows_eff, cols_eff;
  logic [osmw_pkg::AREA_W-1:0] area;
  logic [osmw_pkg::ROW_W-1:0]  orow, orow_next, nr;
  logic [osmw_pkg::COL_W-1:0]  ocol, ocol_next, nc;
  logic [osmw_pkg::CNT_W-1:0]  count, count_next;
  logic [osmw_pkg::ADDR_W-1:0] sweep_addr, sweep_next;
  logic [1:0]                  fill_dir, fill_next;
  logic                        done_next;
  osmw_pkg::rsp_t              rsp_next;
  logic                        accept, legal, moved;
  logic [1:0]                  rd_dir;

  logic [osmw_pkg::ROW_W-1:0]  sw_row;
  logic [osmw_pkg::COL_W-1:0]  sw_col;
  logic [1:0]                  sweep_dir;
  logic                        sweep_hit;

  logic                        ptr_we, ptr_re;
  logic [osmw_pkg::ADDR_W-1:0] ptr_waddr, ptr_raddr;
  logic [1:0]                  ptr_wdata, ptr_rdata;
  logic                        vis_we, vis_re;
  logic [osmw_pkg::ADDR_W-1:0] vis_waddr, vis_raddr;
  logic                        vis_wdata, vis_rdata;

  logic                        div_go;
  osmw_pkg::div_res_t          div_res;

  logic                        in_wb, in_rd, dir_shown;

  assign busy      = (state != osmw_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // size registers clamp to 1..max
  always_comb begin
    if (grid_rows == '0) begin
      rows_eff = osmw_pkg::DIM_W'(1);
    end else if (grid_rows > osmw_pkg::DIM_W'(osmw_pkg::MAX_ROWS)) begin
      rows_eff = osmw_pkg::DIM_W'(osmw_pkg::MAX_ROWS);
    end else begin
      rows_eff = grid_rows;
    end
    if (grid_cols == '0) begin
      cols_eff = osmw_pkg::DIM_W'(1);
    end else if (grid_cols > osmw_pkg::DIM_W'(osmw_pkg::MAX_COLS)) begin
      cols_eff = osmw_pkg::DIM_W'(osmw_pkg::MAX_COLS);
    end else begin
      cols_eff = grid_cols;
    end
    area = osmw_pkg::AREA_W'(rows_eff) * osmw_pkg::AREA_W'(cols_eff);
  end

  // neighbor of the origin and whether the step stays inside
  always_comb begin
    nr    = orow;
    nc    = ocol;
    legal = 1'b0;
    case (req.step_dir)
      osmw_pkg::STEP_UP: begin
        legal = (orow != '0);
        nr    = orow - osmw_pkg::ROW_W'(1);
      end
      osmw_pkg::STEP_DOWN: begin
        legal = ({1'b0, orow} + osmw_pkg::DIM_W'(1)) < rows_eff;
        nr    = orow + osmw_pkg::ROW_W'(1);
      end
      osmw_pkg::STEP_RIGHT: begin
        legal = ({1'b0, ocol} + osmw_pkg::DIM_W'(1)) < cols_eff;
        nc    = ocol + osmw_pkg::COL_W'(1);
      end
      default: begin
        legal = (ocol != '0);
        nc    = ocol - osmw_pkg::COL_W'(1);
      end
    endcase
  end

  // fill value of one cell during the start sweep
  always_comb begin
    sw_row    = sweep_addr[osmw_pkg::ADDR_W-1 -: osmw_pkg::ROW_W];
    sw_col    = sweep_addr[osmw_pkg::COL_W-1:0];
    sweep_dir = fill_dir;
    case (fill_dir)
      osmw_pkg::STEP_UP: begin
        if (sw_row == '0 && {1'b0, sw_col} < cols_eff) sweep_dir = osmw_pkg::STEP_RIGHT;
      end
      osmw_pkg::STEP_DOWN: begin
        if ({1'b0, sw_row} == rows_eff - osmw_pkg::DIM_W'(1) && {1'b0, sw_col} < cols_eff) begin
          sweep_dir = osmw_pkg::STEP_LEFT;
        end
      end
      osmw_pkg::STEP_LEFT: begin
        if (sw_col == '0 && {1'b0, sw_row} < rows_eff) sweep_dir = osmw_pkg::STEP_UP;
      end
      default: begin
        if ({1'b0, sw_col} == cols_eff - osmw_pkg::DIM_W'(1) && {1'b0, sw_row} < rows_eff) begin
          sweep_dir = osmw_pkg::STEP_DOWN;
        end
      end
    endcase
    sweep_hit = (sweep_addr == {orow, ocol});
  end

  always_comb begin
    state_next = state;
    orow_next  = orow;
    ocol_next  = ocol;
    count_next = count;
    sweep_next = sweep_addr;
    fill_next  = fill_dir;
    done_next  = 1'b0;
    moved      = 1'b0;
    rd_dir     = osmw_pkg::STEP_UP;
    ptr_we     = 1'b0;
    ptr_waddr  = {orow, ocol};
    ptr_wdata  = req.step_dir;
    ptr_re     = 1'b0;
    ptr_raddr  = {div_res.quot[osmw_pkg::ROW_W-1:0], div_res.rem[osmw_pkg::COL_W-1:0]};
    vis_we     = 1'b0;
    vis_waddr  = sweep_addr;
    vis_wdata  = 1'b1;
    vis_re     = 1'b0;
    vis_raddr  = {nr, nc};
    div_go     = 1'b0;
    case (state)
      osmw_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.func)
            osmw_pkg::FUNC_START: begin
              fill_next  = req.step_dir;
              sweep_next = '0;
              count_next = osmw_pkg::CNT_W'(area - osmw_pkg::AREA_W'(1));
              state_next = osmw_pkg::ST_SWEEP;
              case (req.step_dir)
                osmw_pkg::STEP_UP: begin
                  orow_next = '0;
                  ocol_next = osmw_pkg::COL_W'(cols_eff - osmw_pkg::DIM_W'(1));
                end
                osmw_pkg::STEP_DOWN: begin
                  orow_next = osmw_pkg::ROW_W'(rows_eff - osmw_pkg::DIM_W'(1));
                  ocol_next = '0;
                end
                osmw_pkg::STEP_LEFT: begin
                  orow_next = '0;
                  ocol_next = '0;
                end
                default: begin
                  orow_next = osmw_pkg::ROW_W'(rows_eff - osmw_pkg::DIM_W'(1));
                  ocol_next = osmw_pkg::COL_W'(cols_eff - osmw_pkg::DIM_W'(1));
                end
              endcase
            end
            osmw_pkg::FUNC_SHIFT: begin
              if (legal) begin
                ptr_we     = 1'b1;
                vis_re     = 1'b1;
                orow_next  = nr;
                ocol_next  = nc;
                state_next = osmw_pkg::ST_SHIFT_WB;
              end else begin
                done_next = 1'b1;
              end
            end
            osmw_pkg::FUNC_READ: begin
              if ({2'b00, req.cell_index} < area) begin
                div_go     = 1'b1;
                state_next = osmw_pkg::ST_RD_DIV;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      osmw_pkg::ST_SWEEP: begin
        ptr_we     = 1'b1;
        ptr_waddr  = sweep_addr;
        ptr_wdata  = sweep_dir;
        vis_we     = 1'b1;
        vis_wdata  = sweep_hit;
        sweep_next = sweep_addr + osmw_pkg::ADDR_W'(1);
        if (sweep_addr == osmw_pkg::ADDR_W'(osmw_pkg::CELLS - 1)) begin
          done_next  = 1'b1;
          state_next = osmw_pkg::ST_IDLE;
        end
      end
      osmw_pkg::ST_SHIFT_WB: begin
        vis_we    = 1'b1;
        vis_waddr = {orow, ocol};
        if (!vis_rdata && count != '0) begin
          count_next = count - osmw_pkg::CNT_W'(1);
        end
        moved      = 1'b1;
        done_next  = 1'b1;
        state_next = osmw_pkg::ST_IDLE;
      end
      osmw_pkg::ST_RD_DIV: begin
        if (div_res.done) begin
          ptr_re     = 1'b1;
          state_next = osmw_pkg::ST_RD_MEM;
        end
      end
      osmw_pkg::ST_RD_MEM: begin
        rd_dir     = ptr_rdata;
        done_next  = 1'b1;
        state_next = osmw_pkg::ST_IDLE;
      end
      default: begin
        state_next = osmw_pkg::ST_IDLE;
      end
    endcase
    rsp_next.origin_row = orow_next;
    rsp_next.origin_col = ocol_next;
    rsp_next.moved      = moved;
    rsp_next.remaining  = count_next;
    rsp_next.complete   = (count_next == '0);
    rsp_next.cell_dir   = rd_dir;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= osmw_pkg::ST_IDLE;
      done      <= 1'b0;
      grid_rows <= osmw_pkg::DIM_RESET;
      grid_cols <= osmw_pkg::DIM_RESET;
      orow      <= '0;
      ocol      <= '0;
      count     <= '0;
    end else begin
      state <= state_next;
      done  <= done_next;
      orow  <= orow_next;
      ocol  <= ocol_next;
      count <= count_next;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == osmw_pkg::REG_ROWS) begin
          grid_rows <= cfg_data;
        end else begin
          grid_cols <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sweep_addr <= sweep_next;
    fill_dir   <= fill_next;
    if (done_next) begin
      rsp <= rsp_next;
    end
  end

  osmw_ram #(
    .ADDR_BITS(osmw_pkg::ADDR_W),
    .DATA_BITS(2)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  osmw_ram #(
    .ADDR_BITS(osmw_pkg::ADDR_W),
    .DATA_BITS(1)
  ) u_vis_ram (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .re    (vis_re),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  osmw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (req.cell_index),
    .divisor  (cols_eff),
    .res      (div_res)
  );

  assign in_wb     = (state == osmw_pkg::ST_SHIFT_WB);
  assign in_rd     = (state == osmw_pkg::ST_RD_MEM);
  assign dir_shown = done && (rsp.cell_dir != osmw_pkg::STEP_UP);

  `OSMW_ASSERT_ALWAYS(a_reset_idle, rst |=> !busy && !done, "not idle after reset")
  `OSMW_ASSERT(a_accept_progress, start && !busy |=> busy || done, "request dropped")
  `OSMW_ASSERT(a_moved_from_wb, done && rsp.moved |-> $past(in_wb), "moved without write-back")
  `OSMW_ASSERT(a_cell_from_read, dir_shown |-> $past(in_rd), "cell value outside read")

endmodule
